/* hw/rtl/stream_substring_replace_defines.svh */
// Assertion macros for the substring replace block.
// Each macro expects clk and rst_n in scope.
`ifndef STREAM_SUBSTRING_REPLACE_DEFINES_SVH
`define STREAM_SUBSTRING_REPLACE_DEFINES_SVH

`ifndef SYNTH

`define SSR_ASSERT_HOLD(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ssr: invariant violated");

`define SSR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssr: implication violated");

`define SSR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssr: next-cycle check violated");

`else

`define SSR_ASSERT_HOLD(label, cond)
`define SSR_ASSERT_IMP(label, ante, cons)
`define SSR_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* hw/rtl/ssr_pkg.sv */
`timescale 1ns / 1ps

package ssr_pkg;

    localparam int MAX_SEARCH_BYTES  = 8;
    localparam int MAX_REPLACE_BYTES = 8;
    localparam int BURST_DEPTH       = 8;
    localparam int LEN_W             = 4;
    localparam int CFG_INDEX_W       = 4;
    localparam int CFG_DATA_W        = 64;

    typedef logic [7:0]       byte_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SEARCH_PATTERN  = 4'd0,
        CFG_SEARCH_LENGTH   = 4'd1,
        CFG_REPLACE_PATTERN = 4'd2,
        CFG_REPLACE_LENGTH  = 4'd3
    } cfg_index_t;

    typedef struct packed {
        byte_t in_byte;
        logic  has_byte;
        logic  end_of_string;
    } src_item_t;

    typedef struct packed {
        byte_t out_byte;
        logic  byte_valid;
        logic  last_out;
    } dst_item_t;

    // results produced by one source item, drained one per transfer
    typedef struct packed {
        logic [BURST_DEPTH-1:0][7:0] data;
        len_t                        cnt;
        logic                        last;
        logic                        marker;
    } burst_t;

endpackage

/* hw/rtl/ssr_engine.sv */
`timescale 1ns / 1ps

module ssr_engine
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   load,
    input  ssr_pkg::src_item_t                     item,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]         search_pattern,
    input  ssr_pkg::len_t                          search_length,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]         replace_pattern,
    input  ssr_pkg::len_t                          replace_length,
    output ssr_pkg::burst_t                        burst,
    output ssr_pkg::len_t                          pending_count
);

    logic [ssr_pkg::BURST_DEPTH-1:0][7:0] window_reg;
    logic [ssr_pkg::BURST_DEPTH-1:0][7:0] window_next;
    ssr_pkg::len_t                        count_reg;
    ssr_pkg::len_t                        count_next;

    always_comb
    begin
        ssr_pkg::len_t                        slen;
        ssr_pkg::len_t                        rlen;
        ssr_pkg::len_t                        c0;
        ssr_pkg::len_t                        c1;
        ssr_pkg::len_t                        n;
        ssr_pkg::len_t                        total;
        logic [ssr_pkg::BURST_DEPTH-1:0][7:0] w;
        logic [ssr_pkg::BURST_DEPTH-1:0][7:0] pre;
        logic                                 match;

        slen  = (search_length > ssr_pkg::len_t'(ssr_pkg::MAX_SEARCH_BYTES)) ?
                ssr_pkg::len_t'(ssr_pkg::MAX_SEARCH_BYTES) : search_length;
        rlen  = (replace_length > ssr_pkg::len_t'(ssr_pkg::MAX_REPLACE_BYTES)) ?
                ssr_pkg::len_t'(ssr_pkg::MAX_REPLACE_BYTES) : replace_length;
        w          = window_reg;
        pre        = '0;
        n          = '0;
        c0         = count_reg;
        c1         = count_reg;
        match      = 1'b0;
        count_next = count_reg;

        if (item.has_byte)
        begin
            if (slen == '0)
            begin
                pre[0] = item.in_byte;
                n      = ssr_pkg::len_t'(1);
            end
            else
            begin
                // a window longer than the pattern keeps only its head
                c0            = (count_reg >= slen) ? slen - ssr_pkg::len_t'(1) : count_reg;
                w[c0[2:0]]    = item.in_byte;
                c1            = c0 + ssr_pkg::len_t'(1);
                count_next    = c1;
                if (c1 == slen)
                begin
                    match = 1'b1;
                    for (int i = 0; i < ssr_pkg::BURST_DEPTH; i++)
                    begin
                        if ((ssr_pkg::len_t'(i) < slen) && (w[i] != search_pattern[8*i +: 8]))
                        begin
                            match = 1'b0;
                        end
                    end
                    if (match)
                    begin
                        for (int i = 0; i < ssr_pkg::BURST_DEPTH; i++)
                        begin
                            pre[i] = replace_pattern[8*i +: 8];
                        end
                        n          = rlen;
                        count_next = '0;
                    end
                    else
                    begin
                        pre[0] = w[0];
                        n      = ssr_pkg::len_t'(1);
                        for (int i = 1; i < ssr_pkg::BURST_DEPTH; i++)
                        begin
                            if (ssr_pkg::len_t'(i) < slen)
                            begin
                                w[i-1] = w[i];
                            end
                        end
                        count_next = slen - ssr_pkg::len_t'(1);
                    end
                end
            end
        end

        window_next = w;
        burst.data  = pre;
        total       = n;
        if (item.end_of_string)
        begin
            // flush pending bytes behind whatever this byte produced
            for (int j = 0; j < ssr_pkg::BURST_DEPTH; j++)
            begin
                if (ssr_pkg::len_t'(j) >= n)
                begin
                    burst.data[j] = w[3'(j) - n[2:0]];
                end
            end
            total      = n + count_next;
            count_next = '0;
        end

        burst.last   = item.end_of_string;
        burst.marker = item.end_of_string && (total == '0);
        burst.cnt    = burst.marker ? ssr_pkg::len_t'(1) : total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
        end
        else if (load)
        begin
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

    assign pending_count = count_reg;

endmodule

/* hw/rtl/stream_substring_replace.sv */
`timescale 1ns / 1ps
// channel | direction | handshake         | payload
// src     | in        | src_valid/stall   | src_item  (in_byte, has_byte, end_of_string)
// dst     | out       | dst_valid/stall   | dst_item  (out_byte, byte_valid, last_out)
// cfg     | in        | cfg_valid/ready   | cfg_index, cfg_data
//
// A src item passes the input register, then the result register, before its first dst transfer.
// Sustains one source byte per cycle while dst does not stall; an item giving k results holds src
// until they drain from the single-read result register, which drains one byte per transfer.
// Items giving no result leave the result register empty and do not hold src. cfg_ready is always high.
// Asynchronous active-low reset clears config, window and all valids.
// dst stall backs up into src stall once the input register is full.

`include "stream_substring_replace_defines.svh"

module stream_substring_replace
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                src_valid,
    output logic                                src_stall,
    input  ssr_pkg::src_item_t                  src_item,
    output logic                                dst_valid,
    input  logic                                dst_stall,
    output ssr_pkg::dst_item_t                  dst_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ssr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [ssr_pkg::CFG_DATA_W-1:0]       search_pattern_reg;
    ssr_pkg::len_t                        search_length_reg;
    logic [ssr_pkg::CFG_DATA_W-1:0]       replace_pattern_reg;
    ssr_pkg::len_t                        replace_length_reg;

    ssr_pkg::src_item_t                   item_reg;
    logic                                 item_valid_reg;
    logic                                 item_valid_next;

    logic [ssr_pkg::BURST_DEPTH-1:0][7:0] burst_data_reg;
    logic [ssr_pkg::BURST_DEPTH-1:0][7:0] burst_data_next;
    ssr_pkg::len_t                        burst_cnt_reg;
    ssr_pkg::len_t                        burst_cnt_next;
    logic                                 burst_last_reg;
    logic                                 burst_marker_reg;

    ssr_pkg::burst_t                      burst;
    ssr_pkg::len_t                        pending_count;
    logic                                 src_xfer;
    logic                                 dst_xfer;
    logic                                 burst_free;
    logic                                 move;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_pattern_reg  <= '0;
            search_length_reg   <= '0;
            replace_pattern_reg <= '0;
            replace_length_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ssr_pkg::CFG_SEARCH_PATTERN:  search_pattern_reg  <= cfg_data;
                ssr_pkg::CFG_SEARCH_LENGTH:   search_length_reg   <= cfg_data[ssr_pkg::LEN_W-1:0];
                ssr_pkg::CFG_REPLACE_PATTERN: replace_pattern_reg <= cfg_data;
                ssr_pkg::CFG_REPLACE_LENGTH:  replace_length_reg  <= cfg_data[ssr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign dst_xfer   = dst_valid && !dst_stall;
    assign burst_free = (burst_cnt_reg == '0) ||
                        ((burst_cnt_reg == ssr_pkg::len_t'(1)) && dst_xfer);
    assign move       = item_valid_reg && burst_free;
    assign src_stall  = item_valid_reg && !move;
    assign src_xfer   = src_valid && !src_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (src_xfer)
        begin
            item_valid_next = 1'b1;
        end
        else if (move)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_xfer)
        begin
            item_reg <= src_item;
        end
    end

    ssr_engine u_engine
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (move),
        .item            (item_reg),
        .search_pattern  (search_pattern_reg),
        .search_length   (search_length_reg),
        .replace_pattern (replace_pattern_reg),
        .replace_length  (replace_length_reg),
        .burst           (burst),
        .pending_count   (pending_count)
    );

    always_comb
    begin
        burst_data_next = burst_data_reg;
        burst_cnt_next  = burst_cnt_reg;
        if (move)
        begin
            burst_data_next = burst.data;
            burst_cnt_next  = burst.cnt;
        end
        else if (dst_xfer)
        begin
            for (int i = 0; i < ssr_pkg::BURST_DEPTH - 1; i++)
            begin
                burst_data_next[i] = burst_data_reg[i+1];
            end
            burst_cnt_next = burst_cnt_reg - ssr_pkg::len_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_cnt_reg    <= '0;
            burst_last_reg   <= 1'b0;
            burst_marker_reg <= 1'b0;
        end
        else
        begin
            burst_cnt_reg <= burst_cnt_next;
            if (move)
            begin
                burst_last_reg   <= burst.last;
                burst_marker_reg <= burst.marker;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        burst_data_reg <= burst_data_next;
    end

    assign dst_valid           = (burst_cnt_reg != '0);
    assign dst_item.out_byte   = burst_marker_reg ? 8'h00 : burst_data_reg[0];
    assign dst_item.byte_valid = !burst_marker_reg;
    assign dst_item.last_out   = burst_last_reg && (burst_cnt_reg == ssr_pkg::len_t'(1));

    `SSR_ASSERT_IMP(a_stall_only_when_full, src_stall, item_valid_reg)
    `SSR_ASSERT_IMP(a_marker_single, dst_valid && burst_marker_reg, (burst_cnt_reg == ssr_pkg::len_t'(1)) && burst_last_reg)
    `SSR_ASSERT_NXT(a_window_empty_after_end, move && item_reg.end_of_string, pending_count == '0)
    `SSR_ASSERT_HOLD(a_window_bound, pending_count < ssr_pkg::len_t'(ssr_pkg::BURST_DEPTH))

endmodule
